// ===== src/wsfp_pkg.sv =====
package wsfp_pkg;

	// what the result word is
	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_STATUS  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_CTRL   = 2'd1,
		ST_BAD_CLOSE  = 2'd2,
		ST_INCOMPLETE = 2'd3
	} status_t;

	localparam logic [3:0]  OP_CLOSE     = 4'h8;
	localparam logic [6:0]  LEN16_CODE   = 7'd126;
	localparam logic [6:0]  LEN64_CODE   = 7'd127;
	localparam logic [63:0] CTRL_MAX_LEN = 64'd125;

	localparam int unsigned TDATA_W = 120;
	localparam int unsigned TUSER_W = 4;

	// one entry of the queue between front and back
	typedef struct packed {
		kind_t       kind;
		status_t     status;
		logic        fin;
		logic [2:0]  rsv;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] length;
		logic [31:0] key;
		logic [7:0]  data;     // raw payload byte, still masked
		logic [1:0]  key_pos;  // key byte index for this payload byte
		logic        last;
	} entry_t;

endpackage

// ===== src/wsfp_front.sv =====
module wsfp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,       // byte accepted this cycle
	input  logic [7:0]         data_byte,
	input  logic               eob,
	output logic               push,
	output wsfp_pkg::entry_t   res
);

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_SECOND  = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	phase_t      ph_q, ph_d;
	logic [7:0]  hdr_q, hdr_d;
	logic        mask_q, mask_d;
	logic [63:0] len_q, len_d;
	logic [3:0]  lenleft_q, lenleft_d;
	logic [31:0] key_q, key_d;
	logic [2:0]  keyleft_q, keyleft_d;
	logic [63:0] pay_q, pay_d;
	logic [1:0]  kpos_q, kpos_d;

	logic                emit;
	logic                len_known;
	logic                hdr_done;
	logic                st_flag;
	wsfp_pkg::status_t   st_code;
	logic                pay_last;

	always_comb begin
		ph_d      = ph_q;
		hdr_d     = hdr_q;
		mask_d    = mask_q;
		len_d     = len_q;
		lenleft_d = lenleft_q;
		key_d     = key_q;
		keyleft_d = keyleft_q;
		pay_d     = pay_q;
		kpos_d    = kpos_q;
		emit      = 1'b0;
		len_known = 1'b0;
		hdr_done  = 1'b0;
		st_flag   = 1'b0;
		st_code   = wsfp_pkg::ST_OK;
		pay_last  = 1'b0;
		res       = '0;

		case (ph_q)
			PH_SECOND: begin
				mask_d = data_byte[7];
				if (data_byte[6:0] == wsfp_pkg::LEN16_CODE ||
				    data_byte[6:0] == wsfp_pkg::LEN64_CODE) begin
					len_d     = '0;
					lenleft_d = (data_byte[6:0] == wsfp_pkg::LEN16_CODE) ? 4'd2 : 4'd8;
					ph_d      = PH_EXTLEN;
					if (eob) begin
						st_flag = 1'b1;
						st_code = wsfp_pkg::ST_INCOMPLETE;
					end
				end else begin
					len_d     = {57'd0, data_byte[6:0]};
					len_known = 1'b1;
				end
			end
			PH_EXTLEN: begin
				len_d     = {len_q[55:0], data_byte};
				lenleft_d = lenleft_q - {3'd0, (lenleft_q != 4'd0)};
				if (lenleft_d == 4'd0) begin
					len_known = 1'b1;
				end else if (eob) begin
					st_flag = 1'b1;
					st_code = wsfp_pkg::ST_INCOMPLETE;
				end
			end
			PH_KEY: begin
				key_d     = {key_q[23:0], data_byte};
				keyleft_d = keyleft_q - {2'd0, (keyleft_q != 3'd0)};
				if (keyleft_d == 3'd0) begin
					hdr_done = 1'b1;
				end else if (eob) begin
					st_flag = 1'b1;
					st_code = wsfp_pkg::ST_INCOMPLETE;
				end
			end
			PH_PAYLOAD: begin
				pay_d    = pay_q - {63'd0, (pay_q != 64'd0)};
				pay_last = (pay_q <= 64'd1);
				if (!pay_last && eob) begin
					st_flag = 1'b1;
					st_code = wsfp_pkg::ST_INCOMPLETE;
				end else begin
					emit        = 1'b1;
					res.kind    = wsfp_pkg::KIND_PAYLOAD;
					res.fin     = hdr_q[7];
					res.rsv     = hdr_q[6:4];
					res.opcode  = hdr_q[3:0];
					res.masked  = mask_q;
					res.length  = len_q;
					res.key     = key_q;
					res.data    = data_byte;
					res.key_pos = kpos_q;
					res.last    = pay_last;
					kpos_d      = kpos_q + 2'd1;
					if (pay_last) begin
						ph_d = PH_IDLE;
					end
				end
			end
			default: begin
				// header byte zero; also recovers from an unused phase code
				hdr_d     = data_byte;
				mask_d    = 1'b0;
				len_d     = '0;
				lenleft_d = '0;
				key_d     = '0;
				keyleft_d = '0;
				pay_d     = '0;
				kpos_d    = '0;
				ph_d      = PH_SECOND;
				if (eob) begin
					st_flag = 1'b1;
					st_code = wsfp_pkg::ST_INCOMPLETE;
				end
			end
		endcase

		// length complete: control-frame checks, then key or header
		if (len_known) begin
			if (hdr_d[3] && (!hdr_d[7] || len_d > wsfp_pkg::CTRL_MAX_LEN)) begin
				st_flag = 1'b1;
				st_code = wsfp_pkg::ST_BAD_CTRL;
			end else if (hdr_d[3:0] == wsfp_pkg::OP_CLOSE && len_d == 64'd1) begin
				st_flag = 1'b1;
				st_code = wsfp_pkg::ST_BAD_CLOSE;
			end else if (mask_d) begin
				ph_d      = PH_KEY;
				keyleft_d = 3'd4;
				key_d     = '0;
				if (eob) begin
					st_flag = 1'b1;
					st_code = wsfp_pkg::ST_INCOMPLETE;
				end
			end else begin
				hdr_done = 1'b1;
			end
		end

		if (hdr_done) begin
			if (eob && len_d != 64'd0) begin
				st_flag = 1'b1;
				st_code = wsfp_pkg::ST_INCOMPLETE;
			end else begin
				emit       = 1'b1;
				res.kind   = wsfp_pkg::KIND_HEADER;
				res.fin    = hdr_d[7];
				res.rsv    = hdr_d[6:4];
				res.opcode = hdr_d[3:0];
				res.masked = mask_d;
				res.length = len_d;
				res.key    = key_d;
				res.last   = (len_d == 64'd0);
				pay_d      = len_d;
				kpos_d     = '0;
				ph_d       = (len_d == 64'd0) ? PH_IDLE : PH_PAYLOAD;
			end
		end

		// any status word drops the frame and clears everything
		if (st_flag) begin
			emit       = 1'b1;
			res        = '0;
			res.kind   = wsfp_pkg::KIND_STATUS;
			res.status = st_code;
			ph_d       = PH_IDLE;
			hdr_d      = '0;
			mask_d     = 1'b0;
			len_d      = '0;
			lenleft_d  = '0;
			key_d      = '0;
			keyleft_d  = '0;
			pay_d      = '0;
			kpos_d     = '0;
		end
	end

	assign push = take && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q      <= PH_IDLE;
			hdr_q     <= '0;
			mask_q    <= 1'b0;
			len_q     <= '0;
			lenleft_q <= '0;
			key_q     <= '0;
			keyleft_q <= '0;
			pay_q     <= '0;
			kpos_q    <= '0;
		end else if (take) begin
			ph_q      <= ph_d;
			hdr_q     <= hdr_d;
			mask_q    <= mask_d;
			len_q     <= len_d;
			lenleft_q <= lenleft_d;
			key_q     <= key_d;
			keyleft_q <= keyleft_d;
			pay_q     <= pay_d;
			kpos_q    <= kpos_d;
		end
	end

	a_status_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push && res.kind == wsfp_pkg::KIND_STATUS |=> ph_q == PH_IDLE && pay_q == 64'd0)
		else $error("state not cleared after status word");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_PAYLOAD |-> pay_q != 64'd0)
		else $error("payload phase with no bytes left");

endmodule

// ===== src/wsfp_queue.sv =====
module wsfp_queue #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] wr_data,
	input  logic             pop,
	output logic [Width-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CntW'(Depth));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(Depth))
		else $error("queue count overflow");

	a_cnt_grow: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not grow on push");

endmodule

// ===== src/wsfp_back.sv =====
module wsfp_back (
	input  wsfp_pkg::entry_t                 head,
	input  logic                             head_valid,
	output logic                             pop,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [wsfp_pkg::TDATA_W-1:0]     m_tdata,
	output logic [wsfp_pkg::TUSER_W-1:0]     m_tuser,
	output logic                             m_tlast
);

	logic [7:0]  key_byte;
	logic [7:0]  plain;
	logic [31:0] key_out;

	// key byte 0 is the first received, in bits 31..24
	always_comb begin
		case (head.key_pos)
			2'd0:    key_byte = head.key[31:24];
			2'd1:    key_byte = head.key[23:16];
			2'd2:    key_byte = head.key[15:8];
			default: key_byte = head.key[7:0];
		endcase
		if (!head.masked) begin
			key_byte = 8'd0;
		end
		plain   = (head.kind == wsfp_pkg::KIND_PAYLOAD) ? (head.data ^ key_byte) : 8'd0;
		key_out = head.masked ? head.key : 32'd0;
	end

	assign m_tvalid = head_valid;
	assign pop      = head_valid && m_tready;
	assign m_tdata  = {7'd0, plain, key_out, head.length, head.masked,
	                   head.opcode, head.rsv, head.fin};
	assign m_tuser  = {head.status, head.kind};
	assign m_tlast  = head.last;

endmodule

// ===== src/websocket_frame_parser.sv =====
// WebSocket frame parser, one stream byte per word.
// Slave channel s_*: one received byte per word, s_tlast marks the last byte
// currently in the buffer. Master channel m_*: at most one result word per
// input byte: a header word once the length and key are in, one word per
// payload byte (unmasked), or a status-only word on a protocol error or a
// buffer that ends inside a frame.
// Each result word is written into the queue and shows on m_* behind older words.
// Throughput: one byte per cycle sustained while the queue is not full; each byte
// is one step of the front-end state machine, whose 64-bit length and payload
// counters set the critical path.
// Results pass through a QueueDepth-entry queue, so the input keeps flowing
// for up to QueueDepth result words while m_tready is low; once the queue is
// full, s_tready drops and rises again the cycle after the receiver takes a word.
// Reset (arst_n low) empties the queue and returns the parser to waiting for
// header byte zero with all header state cleared.
module websocket_frame_parser #(
	parameter int unsigned QueueDepth = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// slave side
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // [7:0] data_byte
	input  logic                             s_tlast,  // end_of_buffer
	// master side
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] fin_flag, [3:1] reserved_bits, [7:4] frame_opcode, [8] is_masked,
	// [72:9] frame length, [104:73] mask key, [112:105] payload_byte,
	// [119:113] zero
	output logic [wsfp_pkg::TDATA_W-1:0]     m_tdata,
	// [1:0] kind, [3:2] status
	output logic [wsfp_pkg::TUSER_W-1:0]     m_tuser,
	output logic                             m_tlast   // last_of_frame
);

	logic             take;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_empty;
	wsfp_pkg::entry_t front_res;
	wsfp_pkg::entry_t q_head;

	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;

	// front: per-byte header/payload state machine
	wsfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (s_tdata),
		.eob       (s_tlast),
		.push      (push),
		.res       (front_res)
	);

	// decouples the parser from the receiver
	wsfp_queue #(
		.Width ($bits(wsfp_pkg::entry_t)),
		.Depth (QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (front_res),
		.pop     (pop),
		.rd_data (q_head),
		.full    (q_full),
		.empty   (q_empty)
	);

	// back: unmasking and word formatting
	wsfp_back u_back (
		.head       (q_head),
		.head_valid (!q_empty),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

// ===== test/tb_top.sv =====
// Byte-stream testbench for websocket_frame_parser.
// A shadow parser in this file follows every accepted byte and queues the
// result word it expects. The receive side pops that queue on each accepted
// result word and compares it field by field.

module tb_top;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned DRAIN_CYCLES = 8;

	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	// shadow parser position within a frame
	typedef enum logic [2:0] {
		AWAIT_HDR0,
		AWAIT_HDR1,
		IN_EXT_LEN,
		IN_KEY,
		IN_PAYLOAD
	} parse_phase_t;

	// how the payload length is encoded on the wire
	typedef enum logic [1:0] {
		LEN_SHORT,
		LEN_EXT16,
		LEN_EXT64
	} len_enc_t;

	// receiver back-pressure styles
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_JITTER,
		RX_BLOCKS
	} rx_style_t;

	// one expected result word, unpacked
	typedef struct {
		wsfp_pkg::kind_t   kind;
		wsfp_pkg::status_t status;
		logic              fin;
		logic [2:0]        rsv;
		logic [3:0]        opcode;
		logic              masked;
		logic [63:0]       length;
		logic [31:0]       key;
		logic [7:0]        pbyte;
		logic              last;
	} frame_word_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [7:0]                     s_tdata;
	logic                           s_tlast;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [wsfp_pkg::TDATA_W-1:0]   m_tdata;
	logic [wsfp_pkg::TUSER_W-1:0]   m_tuser;
	logic                           m_tlast;

	websocket_frame_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	// words the parser still owes us, oldest first
	frame_word_t  expected_words[$];
	int unsigned  mismatch_count = 0;
	int unsigned  cycle_count = 0;

	// sender pacing
	logic         tx_bursty = 1'b0;
	int unsigned  burst_left = 0;

	// receiver pacing
	rx_style_t    rx_style = RX_OPEN;
	int unsigned  rx_hold = 0;

	// shadow parser state
	parse_phase_t parser_phase;
	logic [7:0]   hdr0;
	logic         mask_bit;
	logic [63:0]  len_acc;
	int unsigned  len_bytes_left;
	logic [31:0]  key_reg;
	int unsigned  key_bytes_left;
	logic [63:0]  payload_left;
	logic [1:0]   key_idx;

	// ------------------------------------------------------------------
	// Shadow parser
	// ------------------------------------------------------------------

	task automatic clear_parser();
		parser_phase   = AWAIT_HDR0;
		hdr0           = '0;
		mask_bit       = 1'b0;
		len_acc        = '0;
		len_bytes_left = 0;
		key_reg        = '0;
		key_bytes_left = 0;
		payload_left   = '0;
		key_idx        = '0;
	endtask

	// header fields of the frame in flight; key reads as zero when unmasked
	function automatic frame_word_t header_view(wsfp_pkg::kind_t k);
		frame_word_t w;
		w.kind   = k;
		w.status = wsfp_pkg::ST_OK;
		w.fin    = hdr0[7];
		w.rsv    = hdr0[6:4];
		w.opcode = hdr0[3:0];
		w.masked = mask_bit;
		w.length = len_acc;
		w.key    = mask_bit ? key_reg : 32'd0;
		w.pbyte  = 8'd0;
		w.last   = 1'b0;
		return w;
	endfunction

	// status-only word: everything but kind and status is zero, parser restarts
	task automatic flag_status(input wsfp_pkg::status_t code);
		frame_word_t w;
		w.kind   = wsfp_pkg::KIND_STATUS;
		w.status = code;
		w.fin    = 1'b0;
		w.rsv    = '0;
		w.opcode = '0;
		w.masked = 1'b0;
		w.length = '0;
		w.key    = '0;
		w.pbyte  = '0;
		w.last   = 1'b0;
		expected_words.insert(expected_words.size(), w);
		clear_parser();
	endtask

	// length and key all in
	task automatic finish_header(input logic eob);
		frame_word_t w;
		if (eob && len_acc != 0) begin
			flag_status(wsfp_pkg::ST_INCOMPLETE);
		end else begin
			w = header_view(wsfp_pkg::KIND_HEADER);
			w.last = (len_acc == 0);
			expected_words.insert(expected_words.size(), w);
			payload_left = len_acc;
			key_idx      = '0;
			parser_phase = (len_acc == 0) ? AWAIT_HDR0 : IN_PAYLOAD;
		end
	endtask

	// control-frame rules are judged before any key byte is seen
	task automatic length_resolved(input logic eob);
		if (hdr0[3] && (!hdr0[7] || len_acc > wsfp_pkg::CTRL_MAX_LEN)) begin
			flag_status(wsfp_pkg::ST_BAD_CTRL);
		end else if (hdr0[3:0] == wsfp_pkg::OP_CLOSE && len_acc == 64'd1) begin
			flag_status(wsfp_pkg::ST_BAD_CLOSE);
		end else if (mask_bit) begin
			parser_phase   = IN_KEY;
			key_bytes_left = 4;
			key_reg        = '0;
			if (eob)
				flag_status(wsfp_pkg::ST_INCOMPLETE);
		end else begin
			finish_header(eob);
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic eob);
		frame_word_t w;
		logic [7:0]  kb;
		logic        last;
		case (parser_phase)
		AWAIT_HDR1: begin
			mask_bit = b[7];
			if (b[6:0] == wsfp_pkg::LEN16_CODE || b[6:0] == wsfp_pkg::LEN64_CODE) begin
				len_acc        = '0;
				len_bytes_left = (b[6:0] == wsfp_pkg::LEN16_CODE) ? 2 : 8;
				parser_phase   = IN_EXT_LEN;
				if (eob)
					flag_status(wsfp_pkg::ST_INCOMPLETE);
			end else begin
				len_acc = {57'd0, b[6:0]};
				length_resolved(eob);
			end
		end
		IN_EXT_LEN: begin
			// big-endian: shift in from the bottom
			len_acc = {len_acc[55:0], b};
			if (len_bytes_left > 0)
				len_bytes_left--;
			if (len_bytes_left == 0)
				length_resolved(eob);
			else if (eob)
				flag_status(wsfp_pkg::ST_INCOMPLETE);
		end
		IN_KEY: begin
			key_reg = {key_reg[23:0], b};
			if (key_bytes_left > 0)
				key_bytes_left--;
			if (key_bytes_left == 0)
				finish_header(eob);
			else if (eob)
				flag_status(wsfp_pkg::ST_INCOMPLETE);
		end
		IN_PAYLOAD: begin
			if (payload_left > 0)
				payload_left--;
			last = (payload_left == 0);
			if (!last && eob) begin
				flag_status(wsfp_pkg::ST_INCOMPLETE);
			end else begin
				// first key byte sits in bits 31..24
				kb = mask_bit ? key_reg[8 * (3 - key_idx) +: 8] : 8'd0;
				w = header_view(wsfp_pkg::KIND_PAYLOAD);
				w.pbyte = b ^ kb;
				w.last  = last;
				expected_words.insert(expected_words.size(), w);
				key_idx = key_idx + 2'd1;
				if (last)
					parser_phase = AWAIT_HDR0;
			end
		end
		default: begin
			clear_parser();
			hdr0         = b;
			parser_phase = AWAIT_HDR1;
			if (eob)
				flag_status(wsfp_pkg::ST_INCOMPLETE);
		end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Send side
	// ------------------------------------------------------------------

	// one byte word: optional idle gap when a burst runs out, then hold
	// until accepted and feed the shadow parser
	task automatic send_byte(input logic [7:0] b, input logic eob);
		int unsigned gap;
		if (tx_bursty && burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eob;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (burst_left != 0)
			burst_left--;
		parse_byte(b, eob);
	endtask

	// Build one frame and send it, or its first 'cut' bytes when cut is
	// nonzero and shorter than the frame. Stops early once the parser
	// has rejected the frame; if the frame was left open, one byte with
	// end-of-buffer brings the parser back to the start of a frame.
	task automatic send_frame(input logic [7:0] b0, input logic mbit,
			input logic [63:0] len, input len_enc_t enc, input logic [31:0] key,
			input int unsigned payload_n, input int unsigned cut, input logic eob_end);
		logic [7:0]  bytes_q[$];
		int unsigned n;
		bytes_q.insert(bytes_q.size(), b0);
		case (enc)
		LEN_SHORT: begin
			bytes_q.insert(bytes_q.size(), {mbit, len[6:0]});
		end
		LEN_EXT16: begin
			bytes_q.insert(bytes_q.size(), {mbit, wsfp_pkg::LEN16_CODE});
			bytes_q.insert(bytes_q.size(), len[15:8]);
			bytes_q.insert(bytes_q.size(), len[7:0]);
		end
		default: begin
			bytes_q.insert(bytes_q.size(), {mbit, wsfp_pkg::LEN64_CODE});
			for (int i = 7; i >= 0; i--)
				bytes_q.insert(bytes_q.size(), len[8 * i +: 8]);
		end
		endcase
		if (mbit)
			for (int i = 3; i >= 0; i--)
				bytes_q.insert(bytes_q.size(), key[8 * i +: 8]);
		repeat (payload_n)
			bytes_q.insert(bytes_q.size(), 8'($urandom_range(0, 255)));
		n = (cut != 0 && cut < bytes_q.size()) ? cut : bytes_q.size();
		for (int i = 0; i < n; i++) begin
			send_byte(bytes_q[i], eob_end && (i == n - 1));
			if (parser_phase == AWAIT_HDR0 && i != n - 1)
				break;
		end
		if (parser_phase != AWAIT_HDR0)
			send_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// random frame, legal or breaking control-frame rules, sometimes broken off
	task automatic send_random_frame();
		logic [3:0]  op;
		logic [2:0]  rsv;
		logic        fin;
		logic        mbit;
		logic [63:0] len;
		len_enc_t    enc;
		int unsigned pick;
		int unsigned payload_n;
		int unsigned cut;
		logic        eob_end;
		case ($urandom_range(0, 6))
		0: op = OP_CONT;
		1: op = OP_TEXT;
		2: op = OP_BINARY;
		3: op = wsfp_pkg::OP_CLOSE;
		4: op = OP_PING;
		5: op = OP_PONG;
		default: op = 4'($urandom_range(0, 15));
		endcase
		fin  = ($urandom_range(0, 99) < 85);
		rsv  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
		mbit = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			enc = LEN_SHORT;
			len = 64'($urandom_range(0, 12));
		end else if (pick < 62) begin
			enc = LEN_SHORT;
			len = 64'd1;
		end else if (pick < 68) begin
			enc = LEN_SHORT;
			len = 64'($urandom_range(100, 125));
		end else if (pick < 78) begin
			// includes non-minimal encodings and oversize control lengths
			enc = LEN_EXT16;
			len = 64'($urandom_range(0, 140));
		end else if (pick < 84) begin
			enc = LEN_EXT16;
			len = 64'($urandom_range(0, 65535));
		end else if (pick < 92) begin
			enc = LEN_EXT64;
			len = 64'($urandom_range(0, 20));
		end else begin
			enc = LEN_EXT64;
			len = {$urandom, $urandom};
		end
		// long payloads are only started, then cut by end-of-buffer
		payload_n = (len <= 140) ? 32'(len) : $urandom_range(0, 3);
		eob_end   = (len > 140) || ($urandom_range(0, 3) == 0);
		cut       = 0;
		if ($urandom_range(0, 99) < 12) begin
			cut     = $urandom_range(1, 24);
			eob_end = 1'b1;
		end
		send_frame({fin, rsv, op}, mbit, len, enc, $urandom, payload_n, cut, eob_end);
	endtask

	// ------------------------------------------------------------------
	// Receive side: take result words on the chosen pattern and check them
	// ------------------------------------------------------------------

	task automatic check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		frame_word_t want;
		cycle_count <= cycle_count + 1;
		if (m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word expected none actual kind %0d status %0d",
					$time, m_tuser[1:0], m_tuser[3:2]);
				mismatch_count++;
			end else begin
				want = expected_words.pop_front();
				check_field("kind", 64'(want.kind), 64'(m_tuser[1:0]));
				check_field("status", 64'(want.status), 64'(m_tuser[3:2]));
				check_field("fin_flag", 64'(want.fin), 64'(m_tdata[0]));
				check_field("reserved_bits", 64'(want.rsv), 64'(m_tdata[3:1]));
				check_field("frame_opcode", 64'(want.opcode), 64'(m_tdata[7:4]));
				check_field("is_masked", 64'(want.masked), 64'(m_tdata[8]));
				check_field("frame_len", want.length, m_tdata[72:9]);
				check_field("mask_key", 64'(want.key), 64'(m_tdata[104:73]));
				check_field("payload_byte", 64'(want.pbyte), 64'(m_tdata[112:105]));
				check_field("tdata pad", 64'd0, 64'(m_tdata[119:113]));
				check_field("last_of_frame", 64'(want.last), 64'(m_tlast));
			end
		end
		// back-pressure pattern
		if (rx_hold != 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else begin
			case (rx_style)
			RX_JITTER: m_tready <= ($urandom_range(0, 3) != 0);
			RX_BLOCKS: begin
				if ($urandom_range(0, 7) == 0) begin
					rx_hold = $urandom_range(3, 15);
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
			default: m_tready <= 1'b1;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// corner frames, no idling on either side
	task automatic test_directed();
		tx_bursty = 1'b0;
		rx_style  = RX_OPEN;
		// buffer ends on header byte zero
		send_byte({1'b1, 3'b000, OP_TEXT}, 1'b1);
		// zero-length frame that ends the buffer exactly
		send_frame({1'b1, 3'b000, OP_TEXT}, 1'b0, 64'd0, LEN_SHORT, 32'd0, 0, 0, 1'b1);
		// ping without fin
		send_frame({1'b0, 3'b000, OP_PING}, 1'b0, 64'd0, LEN_SHORT, 32'd0, 0, 0, 1'b0);
		// one-byte close on the last buffered byte: the error wins
		send_frame({1'b1, 3'b000, wsfp_pkg::OP_CLOSE}, 1'b0, 64'd1, LEN_SHORT, 32'd0, 1, 2,
			1'b1);
		// control frame over 125 bytes
		send_frame({1'b1, 3'b000, OP_PING}, 1'b0, 64'd126, LEN_EXT16, 32'd0, 0, 0, 1'b0);
		// fin and all reserved bits set, masked, buffer ends on the last payload byte
		send_frame({1'b1, 3'b111, OP_BINARY}, 1'b1, 64'd2, LEN_SHORT, 32'hFF00_A55A, 2, 0,
			1'b1);
		// widest 64-bit length, then the buffer runs dry inside the payload
		send_frame({1'b1, 3'b000, OP_BINARY}, 1'b0, '1, LEN_EXT64, 32'd0, 1, 0, 1'b1);
	endtask

	task automatic test_random_frames();
		int unsigned goal;
		tx_bursty = 1'b1;
		rx_style  = RX_JITTER;
		goal = $urandom_range(13, 15);
		for (int unsigned sent = 0; sent < goal; sent++)
			send_random_frame();
	endtask

	// sender at full rate into a receiver with long stalls fills the queue
	task automatic test_stalled_receiver();
		tx_bursty = 1'b0;
		rx_style  = RX_BLOCKS;
		repeat (6)
			send_random_frame();
	endtask

	// raw bytes, frequent end-of-buffer marks
	task automatic test_noise();
		tx_bursty = 1'b1;
		rx_style  = RX_JITTER;
		repeat (70)
			send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
	endtask

	initial begin
		clear_parser();
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_frames();
		test_stalled_receiver();
		test_noise();

		s_tvalid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		// catch stray words after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS websocket_frame_parser");
		else
			$display("FAIL websocket_frame_parser");
		$finish;
	end

	// watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout, %0d words still expected", $time, expected_words.size());
		$display("FAIL websocket_frame_parser");
		$finish;
	end

endmodule
